// File: rtl/rate_sum_tree_sampler_core_assert.svh
// Assertion macros shared by the sum tree sampler RTL.
`ifndef RATE_SUM_TREE_SAMPLER_CORE_ASSERT_SVH
`define RATE_SUM_TREE_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RSTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsts_pkg.sv
// Package: widths, codes and types of the sum tree sampler.
`timescale 1ns / 1ps
package rsts_pkg;

    localparam int unsigned LEAVES_DEF    = 1024;
    localparam int unsigned RATE_BITS_DEF = 32;
    localparam int unsigned URN_BITS_DEF  = 32;

    // beat field widths
    localparam int unsigned LEAF_W  = 10;
    localparam int unsigned RATE_W  = 32;
    localparam int unsigned URN_W   = 32;
    localparam int unsigned TOTAL_W = 42;

    // urn digit consumed per multiply-accumulate step
    localparam int unsigned DIG_W = 16;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_U_CMP,
        S_U_ADD,
        S_S_TOT,
        S_S_MUL,
        S_S_DESC
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
    } t_alu_ctl;

endpackage

// File: rtl/rsts_in_if.sv
// Request channel: update or sample beats.
`timescale 1ns / 1ps
interface rsts_in_if import rsts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [LEAF_W-1:0] leaf_index;
    logic [RATE_W-1:0] rate_value;
    logic [URN_W-1:0]  urn;

    modport source (output valid, req_type, leaf_index, rate_value, urn, input ready);
    modport sink   (input valid, req_type, leaf_index, rate_value, urn, output ready);
endinterface

// File: rtl/rsts_out_if.sv
// Result channel: chosen leaf and root total.
`timescale 1ns / 1ps
interface rsts_out_if import rsts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEAF_W-1:0]  chosen_leaf;
    logic [TOTAL_W-1:0] total_rate;
    logic               empty_res;

    modport source (output valid, chosen_leaf, total_rate, empty_res, input ready);
    modport sink   (input valid, chosen_leaf, total_rate, empty_res, output ready);
endinterface

// File: rtl/rsts_tree_mem.sv
// Node sum store: one write port, one registered read port.
`timescale 1ns / 1ps
module rsts_tree_mem #(
    parameter int unsigned AW = 11,
    parameter int unsigned DW = 42
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    localparam int unsigned DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/rsts_alu.sv
// Shared adder: add, subtract with borrow, and digit multiply-accumulate.
`timescale 1ns / 1ps
module rsts_alu import rsts_pkg::*; #(
    parameter int unsigned SUM_W = 42
) (
    input  t_alu_ctl         i_ctl,
    input  logic [SUM_W-1:0] i_a,
    input  logic [SUM_W-1:0] i_b,
    input  logic [DIG_W-1:0] i_digit,
    output logic [SUM_W-1:0] o_res,
    output logic             o_borrow
);
    localparam int unsigned PW = SUM_W + DIG_W;
    localparam int unsigned W  = PW + 1;

    logic [PW-1:0] prod;
    logic [W-1:0]  a_ext;
    logic [W-1:0]  b_ext;
    logic          cin;
    logic [W-1:0]  sum;

    assign prod  = PW'(i_digit) * PW'(i_b);
    assign a_ext = W'(i_a);

    always_comb begin
        unique case (i_ctl.op)
            ALU_ADD: begin
                b_ext = W'(i_b);
                cin   = 1'b0;
            end
            ALU_SUB: begin
                b_ext = ~W'(i_b);
                cin   = 1'b1;
            end
            ALU_MAC: begin
                b_ext = W'(prod);
                cin   = 1'b0;
            end
            default: begin
                b_ext = '0;
                cin   = 1'b0;
            end
        endcase
    end

    assign sum = a_ext + b_ext + W'(cin);

    // MAC result is (acc + d*T) >> DIG_W; dropped bits never feed later carries
    assign o_res    = (i_ctl.op == ALU_MAC) ? sum[DIG_W +: SUM_W] : sum[SUM_W-1:0];
    assign o_borrow = sum[W-1];
endmodule

// File: rtl/rate_sum_tree_sampler_core.sv
// Weighted sampler over a binary sum tree of leaf rates, kept in one node memory.
// After reset the node store is swept to zero, one node per cycle, all 2*P nodes
// (P = LEAVES rounded up to a power of two); no request is taken meanwhile. An
// update that changes a leaf makes one read of the old leaf, then goes one level
// per cycle toward the root, each reading the sibling through the single read
// port and writing the parent. An unchanged rate finishes after the compare with
// the old leaf; an out-of-range leaf is dropped when taken. A sample reads the root,
// multiplies urn by total in 16-bit digits, then descends one tree level per cycle
// through the shared adder. Rates above RATE_BITS saturate. A zero total answers
// leaf 0 with empty_res set. The result sits in an output register; a new request
// is taken while it waits, and a following sample stalls only at its last step.
`timescale 1ns / 1ps
module rate_sum_tree_sampler_core import rsts_pkg::*; #(
    parameter int unsigned LEAVES    = LEAVES_DEF,
    parameter int unsigned RATE_BITS = RATE_BITS_DEF,
    parameter int unsigned URN_BITS  = URN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsts_in_if.sink     i_in,
    rsts_out_if.source  o_out
);
    localparam int unsigned LVL     = $clog2(LEAVES);
    localparam int unsigned AW      = LVL + 1;
    localparam int unsigned SUM_W   = RATE_BITS + LVL;
    localparam int unsigned NDIG    = (URN_BITS + DIG_W - 1) / DIG_W;
    localparam int unsigned URN_PAD = NDIG * DIG_W;
    localparam int unsigned DCW     = $clog2(NDIG + 1);
    localparam int unsigned SAT_W   = (RATE_BITS > RATE_W) ? RATE_BITS : RATE_W;

    localparam logic [AW-1:0]    ROOT     = AW'(1);
    localparam logic [AW-1:0]    CLR_LAST = '1;
    localparam logic [SAT_W-1:0] RMAX     = {SAT_W{1'b1}} >> (SAT_W - RATE_BITS);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_node, n_node;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [SUM_W-1:0]   r_total, n_total;
    logic [URN_PAD-1:0] r_urn, n_urn;
    logic [DCW-1:0]     r_dig, n_dig;
    logic               r_out_valid, n_out_valid;
    logic [LEAF_W-1:0]  r_out_leaf, n_out_leaf;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_empty, n_out_empty;

    logic               in_ready;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [SUM_W-1:0]   mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [SUM_W-1:0]   mem_rdata;
    t_alu_ctl           alu_ctl;
    logic [SUM_W-1:0]   alu_b;
    logic [SUM_W-1:0]   alu_res;
    logic               alu_borrow;

    logic [SAT_W-1:0]   rate_ext;
    logic [SUM_W-1:0]   rate_sat;
    logic [URN_PAD-1:0] urn_al;
    logic [AW-1:0]      leaf_addr;
    logic [AW-1:0]      parent;
    logic [AW-1:0]      desc_next;

    rsts_tree_mem #(
        .AW (AW),
        .DW (SUM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rsts_alu #(
        .SUM_W (SUM_W)
    ) u_alu (
        .i_ctl    (alu_ctl),
        .i_a      (r_acc),
        .i_b      (alu_b),
        .i_digit  (r_urn[DIG_W-1:0]),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign rate_ext  = SAT_W'(i_in.rate_value);
    assign rate_sat  = (rate_ext > RMAX) ? SUM_W'(RMAX) : SUM_W'(rate_ext);
    assign urn_al    = URN_PAD'(URN_BITS'(i_in.urn)) << (URN_PAD - URN_BITS);
    assign leaf_addr = {1'b1, LVL'(i_in.leaf_index)};
    assign parent    = r_node >> 1;
    // descent: go right when x is not below the left sum
    assign desc_next = {r_node[AW-2:0], ~alu_borrow};
    assign out_free  = !r_out_valid || o_out.ready;
    assign alu_b     = (alu_ctl.op == ALU_MAC) ? r_total : mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_acc       <= n_acc;
        r_total     <= n_total;
        r_urn       <= n_urn;
        r_dig       <= n_dig;
        r_out_leaf  <= n_out_leaf;
        r_out_total <= n_out_total;
        r_out_empty <= n_out_empty;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_acc       = r_acc;
        n_total     = r_total;
        n_urn       = r_urn;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_leaf  = r_out_leaf;
        n_out_total = r_out_total;
        n_out_empty = r_out_empty;
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_acc;
        mem_raddr   = r_node;
        alu_ctl.op  = ALU_ADD;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.req_type == REQ_SAMPLE) begin
                        mem_raddr = ROOT;
                        n_urn     = urn_al;
                        n_state   = S_S_TOT;
                    end else if (32'(i_in.leaf_index) < LEAVES) begin
                        mem_raddr = leaf_addr;
                        n_node    = leaf_addr;
                        n_acc     = rate_sat;
                        n_state   = S_U_CMP;
                    end
                end
            end
            S_U_CMP: begin
                if (mem_rdata == r_acc) begin
                    n_state = S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_raddr = r_node ^ AW'(1);
                    n_state   = S_U_ADD;
                end
            end
            S_U_ADD: begin
                // parent = running sum + sibling just read
                alu_ctl.op = ALU_ADD;
                mem_we     = 1'b1;
                mem_waddr  = parent;
                mem_wdata  = alu_res;
                mem_raddr  = parent ^ AW'(1);
                n_acc      = alu_res;
                n_node     = parent;
                if (parent == ROOT) begin
                    n_state = S_IDLE;
                end
            end
            S_S_TOT: begin
                n_total = mem_rdata;
                if (mem_rdata == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_leaf  = '0;
                        n_out_total = '0;
                        n_out_empty = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        mem_raddr = ROOT;
                    end
                end else begin
                    n_acc   = '0;
                    n_dig   = '0;
                    n_state = S_S_MUL;
                end
            end
            S_S_MUL: begin
                alu_ctl.op = ALU_MAC;
                n_acc      = alu_res;
                n_urn      = r_urn >> DIG_W;
                n_dig      = r_dig + DCW'(1);
                if (r_dig == DCW'(NDIG - 1)) begin
                    n_node    = ROOT;
                    mem_raddr = {ROOT[AW-2:0], 1'b0};
                    n_state   = S_S_DESC;
                end
            end
            S_S_DESC: begin
                alu_ctl.op = ALU_SUB;
                if (desc_next[AW-1]) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_leaf  = LEAF_W'(desc_next[LVL-1:0]);
                        n_out_total = TOTAL_W'(r_total);
                        n_out_empty = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        mem_raddr = {r_node[AW-2:0], 1'b0};
                    end
                end else begin
                    if (!alu_borrow) begin
                        n_acc = alu_res;
                    end
                    n_node    = desc_next;
                    mem_raddr = {desc_next[AW-2:0], 1'b0};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.chosen_leaf = r_out_leaf;
    assign o_out.total_rate  = r_out_total;
    assign o_out.empty_res   = r_out_empty;

`include "rate_sum_tree_sampler_core_assert.svh"

    `RSTS_ASSERT_NOW(a_desc_in_range, r_state == S_S_DESC, r_acc < r_total, "urn value not below total during descent")
    `RSTS_ASSERT_NOW(a_result_src, $rose(r_out_valid), $past(r_state) == S_S_TOT || $past(r_state) == S_S_DESC, "result loaded outside sample path")
    `RSTS_ASSERT_NOW(a_empty_zero, r_out_valid && r_out_empty, r_out_total == '0 && r_out_leaf == '0, "empty result with nonzero fields")
    `RSTS_ASSERT_NEXT(a_upd_no_result, i_in.valid && i_in.ready && i_in.req_type == REQ_UPDATE, !$rose(r_out_valid), "update produced a result")
    `RSTS_ASSERT_NOW(a_upd_path, r_state == S_U_ADD, r_node != '0 && r_node != ROOT, "update walk left the tree")
endmodule

// File: test/testbench.sv
// Testbench for the sum tree sampler: update and sample beats checked against a local tree.
`timescale 1ns / 1ps
module testbench import rsts_pkg::*;;

    localparam int unsigned TREE_P       = 1 << $clog2(LEAVES_DEF);
    localparam logic [63:0] RATE_MAX     = (64'd1 << RATE_BITS_DEF) - 1;
    localparam logic [URN_W-1:0] URN_MASK = URN_W'((64'd1 << URN_BITS_DEF) - 1);
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [LEAF_W-1:0]  leaf;
        logic [TOTAL_W-1:0] total;
        logic               empty;
    } t_draw_result;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_BLOCKY
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    rsts_in_if  req_bus ();
    rsts_out_if draw_bus ();

    rate_sum_tree_sampler_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (draw_bus)
    );

    // heap-ordered node sums: root at 1, leaves at TREE_P..2*TREE_P-1
    bit [TOTAL_W-1:0] tree_sums [1:2*TREE_P-1];
    t_draw_result     pending_draws [$];
    int unsigned      touched_leaves [$];

    int unsigned burst_left = 0;
    int unsigned errors = 0;
    int unsigned n_updates = 0;
    int unsigned n_changed = 0;
    int unsigned n_draws = 0;
    int unsigned n_empty_draws = 0;
    int unsigned n_checked = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Writes one leaf and refreshes the path to the root; returns 1 if the leaf changed.
    function automatic bit write_leaf_rate(input logic [LEAF_W-1:0] leaf,
                                           input logic [RATE_W-1:0] rate);
        logic [63:0] level;
        int unsigned node;
        level = 64'(rate);
        if (level > RATE_MAX) level = RATE_MAX;
        if (leaf >= LEAVES_DEF) return 1'b0;
        node = TREE_P + leaf;
        if (tree_sums[node] == level[TOTAL_W-1:0]) return 1'b0;
        tree_sums[node] = level[TOTAL_W-1:0];
        for (node = node >> 1; node >= 1; node = node >> 1)
            tree_sums[node] = tree_sums[2*node] + tree_sums[2*node+1];
        return 1'b1;
    endfunction

    function automatic t_draw_result predict_draw(input logic [URN_W-1:0] urn);
        t_draw_result r;
        logic [URN_W+TOTAL_W-1:0] scaled;
        logic [URN_W-1:0]         frac;
        logic [TOTAL_W-1:0]       x;
        logic [TOTAL_W-1:0]       lsum;
        int unsigned              node;
        r.total = tree_sums[1];
        r.leaf  = '0;
        r.empty = 1'b1;
        if (r.total == 0) return r;
        frac   = urn & URN_MASK;
        scaled = {{TOTAL_W{1'b0}}, frac} * {{URN_W{1'b0}}, r.total};
        x      = TOTAL_W'(scaled >> URN_BITS_DEF);   // always below total
        node   = 1;
        while (node < TREE_P) begin
            lsum = tree_sums[2*node];
            if (x < lsum) begin
                node = 2*node;
            end else begin
                x    = x - lsum;
                node = 2*node + 1;
            end
        end
        r.leaf  = LEAF_W'(node - TREE_P);
        r.empty = 1'b0;
        return r;
    endfunction

    function automatic logic [URN_W-1:0] pick_urn();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Drives one beat and waits for it to be taken; predicts at acceptance.
    task automatic send_req(input logic kind, input logic [LEAF_W-1:0] leaf,
                            input logic [RATE_W-1:0] rate, input logic [URN_W-1:0] urn);
        t_draw_result want;
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat (($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1))
                @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(12, 1);
        end
        burst_left--;
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.leaf_index <= leaf;
        req_bus.rate_value <= rate;
        req_bus.urn        <= urn;
        do @(posedge i_clk); while (!req_bus.ready);
        if (kind == REQ_UPDATE) begin
            n_updates++;
            touched_leaves.insert(touched_leaves.size(), 32'(leaf));
            if (write_leaf_rate(leaf, rate)) n_changed++;
        end else begin
            want = predict_draw(urn);
            if (want.empty) n_empty_draws++;
            n_draws++;
            pending_draws.insert(pending_draws.size(), want);
        end
    endtask

    task automatic send_update(input logic [LEAF_W-1:0] leaf, input logic [RATE_W-1:0] rate);
        send_req(REQ_UPDATE, leaf, rate, $urandom());
    endtask

    task automatic send_draw(input logic [URN_W-1:0] urn);
        send_req(REQ_SAMPLE, LEAF_W'($urandom_range(TREE_P - 1, 0)), $urandom(), urn);
    endtask

    // Empty tree, single heavy leaf, unchanged writes, urn extremes, back to empty.
    task automatic test_directed_corners();
        send_draw('0);
        send_draw('1);
        send_update(0, '0);
        send_update(LEAVES_DEF - 1, '1);
        send_draw('0);
        send_draw('1);
        send_update(0, 32'd1);
        send_draw('0);
        send_draw('1);
        send_update(LEAVES_DEF - 1, '1);
        send_update(LEAVES_DEF / 2, 32'h8000_0000);
        send_update(LEAVES_DEF / 2 - 1, 32'h7FFF_FFFF);
        send_draw(32'h8000_0000);
        send_draw(32'h7FFF_FFFF);
        send_draw(32'h4000_0000);
        send_update(LEAVES_DEF - 1, '0);
        send_update(0, '0);
        send_update(LEAVES_DEF / 2 - 1, '0);
        send_update(LEAVES_DEF / 2, '0);
        send_draw($urandom());
    endtask

    // Few live leaves clustered together, so most subtrees are zero.
    task automatic test_sparse_cluster(input int unsigned count);
        int unsigned base;
        logic [RATE_W-1:0] rate;
        base = 0;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 100 == 0) base = $urandom_range(LEAVES_DEF - 16, 0);
            if ($urandom_range(1, 0) == 0) begin
                send_draw(pick_urn());
            end else begin
                case ($urandom_range(4, 0))
                    0, 1: rate = '0;
                    2: rate = $urandom_range(255, 1);
                    3: rate = 32'd1 << $urandom_range(31, 0);
                    default: rate = $urandom();
                endcase
                send_update(LEAF_W'(base + $urandom_range(15, 0)), rate);
            end
        end
    endtask

    // Leaves all over the range, many near the top rate to push the total high.
    task automatic test_dense_tree(input int unsigned count);
        logic [RATE_W-1:0] rate;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(99, 0) < 55) begin
                send_draw(pick_urn());
            end else begin
                rate = ($urandom_range(4, 0) < 2) ? 32'hFFFF_FFFF - $urandom_range(3, 0)
                                                  : $urandom();
                send_update(LEAF_W'($urandom_range(LEAVES_DEF - 1, 0)), rate);
            end
        end
    endtask

    // Writes of the value a leaf already holds, other writes and samples; most writes repeat the held value.
    task automatic test_rewrites(input int unsigned count);
        int unsigned leaf;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(19, 0)) inside
                [0:6]: begin
                    leaf = touched_leaves[$urandom_range(touched_leaves.size() - 1, 0)];
                    send_update(LEAF_W'(leaf), tree_sums[TREE_P + leaf][RATE_W-1:0]);
                end
                [7:10]: send_update(LEAF_W'($urandom_range(LEAVES_DEF - 1, 0)), $urandom());
                default: send_draw(pick_urn());
            endcase
        end
    endtask

    // Zero every live leaf, sampling along the way, then sample the empty tree.
    task automatic test_drain_to_empty();
        int unsigned since_draw;
        since_draw = 0;
        for (int unsigned i = 0; i < LEAVES_DEF; i++) begin
            if (tree_sums[TREE_P + i] != 0) begin
                send_update(LEAF_W'(i), '0);
                since_draw++;
                if (since_draw == 32) begin
                    send_draw(pick_urn());
                    since_draw = 0;
                end
            end
        end
        repeat (3) send_draw(pick_urn());
    endtask

    // Result side: check each accepted beat, then choose ready for the next edge.
    initial begin : draw_sink
        t_draw_result want;
        t_sink_mode   mode;
        int unsigned  mode_left;
        int unsigned  stall_left;
        mode       = SINK_OPEN;
        mode_left  = 200;
        stall_left = 0;
        draw_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && draw_bus.valid && draw_bus.ready) begin
                n_checked++;
                if (pending_draws.size() == 0) begin
                    $error("unexpected result: chosen_leaf %0d total_rate %0d empty_res %0b",
                           draw_bus.chosen_leaf, draw_bus.total_rate, draw_bus.empty_res);
                    errors++;
                end else begin
                    want = pending_draws.pop_front();
                    if (draw_bus.chosen_leaf !== want.leaf) begin
                        $error("chosen_leaf: expected %0d, got %0d",
                               want.leaf, draw_bus.chosen_leaf);
                        errors++;
                    end
                    if (draw_bus.total_rate !== want.total) begin
                        $error("total_rate: expected %0d, got %0d",
                               want.total, draw_bus.total_rate);
                        errors++;
                    end
                    if (draw_bus.empty_res !== want.empty) begin
                        $error("empty_res: expected %0b, got %0b",
                               want.empty, draw_bus.empty_res);
                        errors++;
                    end
                end
            end
            if (mode_left == 0) begin
                mode       = t_sink_mode'($urandom_range(2, 0));
                mode_left  = $urandom_range(300, 50);
                stall_left = 0;
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   draw_bus.ready <= 1'b1;
                SINK_CHOPPY: draw_bus.ready <= 1'($urandom_range(1, 0));
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        draw_bus.ready <= 1'b0;
                    end else begin
                        if ($urandom_range(2, 0) == 0) stall_left = $urandom_range(12, 1);
                        draw_bus.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog; the limit also covers the clearing sweep after reset.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : main_seq
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_UPDATE;
        req_bus.leaf_index <= '0;
        req_bus.rate_value <= '0;
        req_bus.urn        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_sparse_cluster(400);
        test_dense_tree(600);
        test_rewrites(250);
        test_drain_to_empty();

        req_bus.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_draws.size() != 0) begin
            $error("%0d expected results never arrived", pending_draws.size());
            errors++;
        end
        $display("Covered %0d updates (%0d changed a leaf), %0d samples (%0d on an empty tree).",
                 n_updates, n_changed, n_draws, n_empty_draws);
        $display("Checked %0d results in %0d cycles, %0d mismatches.",
                 n_checked, cycle_count, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: rate_sum_tree_sampler_core.f
+incdir+rtl
rtl/rsts_pkg.sv
rtl/rsts_in_if.sv
rtl/rsts_out_if.sv
rtl/rsts_tree_mem.sv
rtl/rsts_alu.sv
rtl/rate_sum_tree_sampler_core.sv
test/testbench.sv
